>>> rtl/core/stac_pkg.sv
`timescale 1ns / 1ps

package stac_pkg;

  localparam int PID_W   = 8;
  localparam int SID_W   = 16;
  localparam int BASE_W  = 10;
  localparam int SIZE_W  = 10;
  localparam int LIMIT_W = 20;
  localparam int STAT_W  = 3;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'hFFFFF;

  // Command codes
  localparam logic CMD_ALLOC  = 1'b0;
  localparam logic CMD_ACCESS = 1'b1;

  // Register indexes
  localparam logic REG_CAPACITY_LIMIT = 1'b0;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_TAKEN     = 3'd1,
    ST_CAPACITY  = 3'd2,
    ST_NOT_OWNER = 3'd3,
    ST_WRONG_ID  = 3'd4,
    ST_BOUNDS    = 3'd5,
    ST_MISSING   = 3'd6,
    ST_FULL      = 3'd7
  } stac_status_t;

  typedef struct packed {
    logic              cmd;
    logic [PID_W-1:0]  pid;
    logic [SID_W-1:0]  sid;
    logic [BASE_W-1:0] base;
    logic [SIZE_W-1:0] size;
  } stac_req_t;

  typedef struct packed {
    logic         valid;
    logic         done;
    stac_status_t status;
  } stac_ctl_t;

endpackage

>>> rtl/core/stac_cell.sv
`timescale 1ns / 1ps

module stac_cell #(
  parameter int SUM_W = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_range,
  input  logic [stac_pkg::LIMIT_W-1:0]  limit,
  input  stac_pkg::stac_req_t           req_in,
  input  stac_pkg::stac_ctl_t           ctl_in,
  input  logic [SUM_W-1:0]              sum_in,
  input  logic                          wr_en,
  input  stac_pkg::stac_req_t           wr_req,
  output stac_pkg::stac_req_t           req_out,
  output stac_pkg::stac_ctl_t           ctl_out,
  output logic [SUM_W-1:0]              sum_out
);
  import stac_pkg::*;

  localparam int CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

  logic [PID_W-1:0]  entry_owner;
  logic [SID_W-1:0]  entry_ident;
  logic [BASE_W-1:0] entry_base;
  logic [SIZE_W-1:0] entry_size;

  logic [SUM_W-1:0]  sum_next;
  logic [SUM_W-1:0]  total;
  stac_ctl_t         ctl_next;
  logic              base_hit;

  always_comb begin
    sum_next = sum_in;
    ctl_next = ctl_in;
    base_hit = (entry_base == req_in.base);
    total    = sum_in + SUM_W'(entry_size) + SUM_W'(req_in.size);
    if (ctl_in.valid && in_range && !ctl_in.done) begin
      if (req_in.cmd == CMD_ALLOC) begin
        sum_next = sum_in + SUM_W'(entry_size);
        if (base_hit) begin
          ctl_next.done   = 1'b1;
          ctl_next.status = ST_TAKEN;
        end else if (CMP_W'(total) > CMP_W'(limit)) begin
          ctl_next.done   = 1'b1;
          ctl_next.status = ST_CAPACITY;
        end
      end else if (base_hit) begin
        ctl_next.done = 1'b1;
        priority if (entry_owner != req_in.pid) begin
          ctl_next.status = ST_NOT_OWNER;
        end else if (entry_ident != req_in.sid) begin
          ctl_next.status = ST_WRONG_ID;
        end else if (entry_size < req_in.size) begin
          ctl_next.status = ST_BOUNDS;
        end else begin
          ctl_next.status = ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_next.valid;
    end
    if (en) begin
      ctl_out.done   <= ctl_next.done;
      ctl_out.status <= ctl_next.status;
      req_out        <= req_in;
      sum_out        <= sum_next;
    end
    if (wr_en) begin
      entry_owner <= wr_req.pid;
      entry_ident <= wr_req.sid;
      entry_base  <= wr_req.base;
      entry_size  <= wr_req.size;
    end
  end

endmodule

>>> rtl/core/segment_table_alloc_access_check.sv
`timescale 1ns / 1ps
// Segment table with allocate and access checks.
// Input channel (in_valid / in_stall) carries one request item: cmd, process_id,
// segment_id, segment_base, request_size. Output channel (out_valid / out_stall)
// returns one status item per request.
// The table is a row of TABLE_DEPTH cells, one entry each. A request token walks
// the row one cell per cycle unless frozen, carrying the running size sum, then a
// finish step picks the status and appends the entry on a good allocate.
// One request is in the row at a time; a new one is taken only as the last one
// leaves the row through the finish step. A finished status waits in the output
// register while the next request walks. When out_stall holds a status and
// another token reaches the row's end, the whole row freezes until the status
// is taken. capacity_limit is written at APB byte address 0; the user must
// write it only while the block is idle; the block itself does not enforce this.
// Reset (rst, synchronous) empties the table and sets capacity_limit to all ones.
module segment_table_alloc_access_check #(
  parameter int TABLE_DEPTH = stac_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [stac_pkg::PID_W-1:0]    process_id,
  input  logic [stac_pkg::SID_W-1:0]    segment_id,
  input  logic [stac_pkg::BASE_W-1:0]   segment_base,
  input  logic [stac_pkg::SIZE_W-1:0]   request_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stac_pkg::STAT_W-1:0]   status
);
  import stac_pkg::*;

  localparam int SUM_W = $clog2((TABLE_DEPTH + 1) * (1 << SIZE_W));
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [LIMIT_W-1:0] capacity_limit;
  logic [CNT_W-1:0]   entry_count;
  logic               busy;
  logic               adv;
  logic               fin;
  logic               in_acc;
  logic               entry_wr;
  stac_status_t       fin_status;
  stac_status_t       status_reg;
  logic [TABLE_DEPTH:0] tok_vld;

  stac_req_t          req_chain [0:TABLE_DEPTH];
  stac_ctl_t          ctl_chain [0:TABLE_DEPTH];
  logic [SUM_W-1:0]   sum_chain [0:TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] in_range;
  logic [TABLE_DEPTH-1:0] cell_wr;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY_LIMIT) ? 32'(capacity_limit) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY_LIMIT) begin
      capacity_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // Freeze the row when a finished token meets a held status.
  assign fin      = ctl_chain[TABLE_DEPTH].valid;
  assign adv      = !(fin && out_valid && out_stall);
  assign in_stall = busy && !(fin && adv);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy              <= 1'b0;
      ctl_chain[0].valid <= 1'b0;
    end else begin
      if (in_acc) begin
        busy <= 1'b1;
      end else if (fin && adv) begin
        busy <= 1'b0;
      end
      if (adv) begin
        ctl_chain[0].valid <= in_acc;
      end
    end
    if (adv) begin
      req_chain[0].cmd    <= cmd;
      req_chain[0].pid    <= process_id;
      req_chain[0].sid    <= segment_id;
      req_chain[0].base   <= segment_base;
      req_chain[0].size   <= request_size;
      ctl_chain[0].done   <= 1'b0;
      ctl_chain[0].status <= ST_OK;
      sum_chain[0]        <= '0;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign in_range[i] = (CNT_W'(i) < entry_count);
    assign cell_wr[i]  = entry_wr && (entry_count == CNT_W'(i));

    stac_cell #(
      .SUM_W (SUM_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_range (in_range[i]),
      .limit    (capacity_limit),
      .req_in   (req_chain[i]),
      .ctl_in   (ctl_chain[i]),
      .sum_in   (sum_chain[i]),
      .wr_en    (cell_wr[i]),
      .wr_req   (req_chain[TABLE_DEPTH]),
      .req_out  (req_chain[i+1]),
      .ctl_out  (ctl_chain[i+1]),
      .sum_out  (sum_chain[i+1])
    );
  end

  for (genvar j = 0; j <= TABLE_DEPTH; j++) begin : g_vld
    assign tok_vld[j] = ctl_chain[j].valid;
  end

  // Finish step at the end of the row
  always_comb begin
    fin_status = ctl_chain[TABLE_DEPTH].status;
    entry_wr   = 1'b0;
    if (!ctl_chain[TABLE_DEPTH].done) begin
      if (req_chain[TABLE_DEPTH].cmd == CMD_ALLOC) begin
        priority if (entry_count == '0 &&
                     LIMIT_W'(req_chain[TABLE_DEPTH].size) > capacity_limit) begin
          fin_status = ST_CAPACITY;
        end else if (entry_count == CNT_W'(TABLE_DEPTH)) begin
          fin_status = ST_FULL;
        end else begin
          fin_status = ST_OK;
          entry_wr   = fin && adv;
        end
      end else begin
        fin_status = ST_MISSING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (entry_wr) begin
        entry_count <= entry_count + 1'b1;
      end
      if (fin && adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin && adv) begin
      status_reg <= fin_status;
    end
  end

  assign status = status_reg;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_vld) <= 1)
    else $error("more than one request in the row");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> tok_vld == '0)
    else $error("token in the row while idle");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fin && adv))
    else $error("status shown without a finished token");
`endif

endmodule

>>> sim/tb_segment_table_alloc_access_check.sv
`timescale 1ns / 1ps

module tb_segment_table_alloc_access_check;
  import stac_pkg::*;

  localparam int DEPTH          = TABLE_DEPTH_DEF;
  localparam int DUT_LATENCY    = DEPTH + 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_PHASES     = 6;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [2:0]          paddr        = '0;
  logic [31:0]         pwdata       = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic                cmd          = CMD_ALLOC;
  logic [PID_W-1:0]    process_id   = '0;
  logic [SID_W-1:0]    segment_id   = '0;
  logic [BASE_W-1:0]   segment_base = '0;
  logic [SIZE_W-1:0]   request_size = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [STAT_W-1:0]   status;

  segment_table_alloc_access_check dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .process_id   (process_id),
    .segment_id   (segment_id),
    .segment_base (segment_base),
    .request_size (request_size),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status)
  );

  always #5 clk = ~clk;

  // Segment table as the block should hold it
  logic [PID_W-1:0]   tab_owner [DEPTH];
  logic [SID_W-1:0]   tab_ident [DEPTH];
  logic [BASE_W-1:0]  tab_base  [DEPTH];
  logic [SIZE_W-1:0]  tab_size  [DEPTH];
  int                 seg_count = 0;
  logic [LIMIT_W-1:0] cap_limit = LIMIT_RESET;

  stac_req_t     pend_q [$];
  stac_status_t  status_q [$];
  stac_req_t     drv_req;
  int            queued_cnt   = 0;
  int            accepted_cnt = 0;
  int            checked_cnt  = 0;
  int            settings_cnt = 0;
  int            error_cnt    = 0;
  int            status_seen [8];
  int            gap_left     = 0;
  int            stall_left   = 0;
  int            quiet_cycles = 0;
  logic          in_taken     = 1'b0;
  logic          no_idle      = 1'b0;

  function automatic stac_status_t predict_status(input logic c, input logic [PID_W-1:0] pid,
                                                  input logic [SID_W-1:0] sid,
                                                  input logic [BASE_W-1:0] base,
                                                  input logic [SIZE_W-1:0] size);
    int unsigned running;
    int i;
    running = 0;
    if (c == CMD_ALLOC) begin
      if (seg_count == 0 && size > cap_limit) return ST_CAPACITY;
      for (i = 0; i < seg_count; i++) begin
        running += tab_size[i];
        if (tab_base[i] == base) return ST_TAKEN;
        if (running + size > cap_limit) return ST_CAPACITY;
      end
      if (seg_count >= DEPTH) return ST_FULL;
      tab_owner[seg_count] = pid;
      tab_ident[seg_count] = sid;
      tab_base[seg_count]  = base;
      tab_size[seg_count]  = size;
      seg_count++;
      return ST_OK;
    end
    for (i = 0; i < seg_count; i++) begin
      if (tab_base[i] == base) begin
        if (tab_owner[i] != pid) return ST_NOT_OWNER;
        if (tab_ident[i] != sid) return ST_WRONG_ID;
        if (tab_size[i] < size) return ST_BOUNDS;
        return ST_OK;
      end
    end
    return ST_MISSING;
  endfunction

  // Input side: hold each item until taken, idle in bursts between items
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pend_q.size() > 0) begin
        drv_req = pend_q.pop_front();
        cmd          <= drv_req.cmd;
        process_id   <= drv_req.pid;
        segment_id   <= drv_req.sid;
        segment_base <= drv_req.base;
        request_size <= drv_req.size;
        in_valid     <= 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: stall in bursts
  always @(negedge clk) begin
    if (rst || no_idle) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 11);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        status_q.push_back(predict_status(cmd, process_id, segment_id, segment_base,
                                          request_size));
        accepted_cnt++;
      end
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          error_cnt++;
          if (error_cnt <= MAX_REPORTS)
            $display("unexpected result: status %0d with nothing outstanding", status);
        end else begin
          stac_status_t want;
          want = status_q.pop_front();
          checked_cnt++;
          status_seen[status]++;
          if (status !== want) begin
            error_cnt++;
            if (error_cnt <= MAX_REPORTS)
              $display("status mismatch on result %0d: expected %0d, got %0d",
                       checked_cnt, want, status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("segment_table_alloc_access_check test failed");
      $finish;
    end
  end

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(4 * int'(REG_CAPACITY_LIMIT));
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    cap_limit = value;
    settings_cnt++;
    // read back with psel kept high
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[LIMIT_W-1:0] !== value) begin
      error_cnt++;
      if (error_cnt <= MAX_REPORTS)
        $display("capacity_limit readback: expected %0d, got %0d", value,
                 prdata[LIMIT_W-1:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_room();
    while (pend_q.size() >= 2) begin
      @(posedge clk);
      #1;
    end
  endtask

  task automatic send(input logic c, input int pid, input int sid, input int base,
                      input int size);
    stac_req_t r;
    r.cmd  = c;
    r.pid  = PID_W'(pid);
    r.sid  = SID_W'(sid);
    r.base = BASE_W'(base);
    r.size = SIZE_W'(size);
    wait_room();
    pend_q.push_back(r);
    queued_cnt++;
  endtask

  // Mostly accesses to live segments and fresh allocates, with noise mixed in
  task automatic add_random_item();
    stac_req_t r;
    int sel;
    int idx;
    wait_room();
    sel    = $urandom_range(0, 99);
    r.cmd  = CMD_ALLOC;
    r.pid  = PID_W'($urandom);
    r.sid  = SID_W'($urandom);
    r.base = BASE_W'($urandom);
    r.size = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(0, 255));
    if (sel < 12 && seg_count > 0) begin
      r.base = tab_base[$urandom_range(0, seg_count - 1)];
    end else if (sel >= 30 && sel < 85 && seg_count > 0) begin
      idx    = $urandom_range(0, seg_count - 1);
      r.cmd  = CMD_ACCESS;
      r.pid  = tab_owner[idx];
      r.sid  = tab_ident[idx];
      r.base = tab_base[idx];
      case ($urandom_range(0, 3))
        0:       r.size = tab_size[idx];
        1:       r.size = tab_size[idx] + 1'b1;
        2:       r.size = SIZE_W'($urandom_range(0, tab_size[idx]));
        default: r.size = SIZE_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0:       r.pid = r.pid ^ PID_W'($urandom_range(1, 255));
        1:       r.sid = r.sid ^ SID_W'($urandom_range(1, 65535));
        default: ;
      endcase
    end else if (sel >= 85) begin
      r.cmd = 1'($urandom);
    end
    pend_q.push_back(r);
    queued_cnt++;
  endtask

  task automatic drain();
    while (accepted_cnt != queued_cnt || status_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (DUT_LATENCY) @(posedge clk);
  endtask

  initial begin
    logic [LIMIT_W-1:0] phase_limit [NUM_PHASES];
    int                 phase_items [NUM_PHASES];
    int                 p;
    int                 n;
    phase_limit = '{LIMIT_W'($urandom_range(2100, 4000)), LIMIT_RESET,
                    LIMIT_W'($urandom_range(0, 8000)), LIMIT_W'($urandom_range(0, 8000)),
                    '0, LIMIT_RESET};
    phase_items = '{130, 130, 100, 100, 80, 150};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero limit: empty-table capacity, zero size, taken, bounds and lookup errors
    write_limit('0);
    send(CMD_ALLOC,  1, 10, 5, 1);
    send(CMD_ALLOC,  1, 10, 5, 0);
    send(CMD_ALLOC,  2, 11, 5, 0);
    send(CMD_ALLOC,  2, 11, 6, 1);
    send(CMD_ACCESS, 1, 10, 5, 0);
    send(CMD_ACCESS, 1, 10, 5, 1);
    send(CMD_ACCESS, 3, 10, 5, 0);
    send(CMD_ACCESS, 1, 99, 5, 0);
    send(CMD_ACCESS, 1, 10, 7, 0);
    drain();

    // Full-scale limit: field extremes, request size equal to segment size
    write_limit(LIMIT_RESET);
    send(CMD_ALLOC,  255, 65535, 1023, 1023);
    send(CMD_ALLOC,  0,   0,     0,    1023);
    send(CMD_ACCESS, 255, 65535, 1023, 1023);
    send(CMD_ACCESS, 0,   0,     0,    1023);
    send(CMD_ACCESS, 0,   0,     0,    0);
    send(CMD_ACCESS, 254, 65535, 1023, 0);
    send(CMD_ACCESS, 255, 65534, 1023, 0);
    send(CMD_ACCESS, 0,   0,     512,  0);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) no_idle = 1'b1;
      write_limit(phase_limit[p]);
      for (n = 0; n < phase_items[p]; n++) add_random_item();
      drain();
    end

    if (status_q.size() != 0) begin
      error_cnt++;
      $display("%0d results never arrived", status_q.size());
    end
    $display("checked %0d requests under %0d capacity settings, table holds %0d entries",
             checked_cnt, settings_cnt, seg_count);
    $display("ok %0d taken %0d capacity %0d owner %0d id %0d bounds %0d missing %0d full %0d",
             status_seen[ST_OK], status_seen[ST_TAKEN], status_seen[ST_CAPACITY],
             status_seen[ST_NOT_OWNER], status_seen[ST_WRONG_ID], status_seen[ST_BOUNDS],
             status_seen[ST_MISSING], status_seen[ST_FULL]);
    if (error_cnt == 0) begin
      $display("segment_table_alloc_access_check test passed");
    end else begin
      $display("%0d failures", error_cnt);
      $display("segment_table_alloc_access_check test failed");
    end
    $finish;
  end

endmodule
